// ===== sv/pip_pkg.sv =====
// Shared constants, stage types and edge setup function for the polygon tester.
package pip_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_VERTICES = 1024;
    localparam int AREA_BITS    = 43;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int CROSS_W      = 2 * DIFF_W;
    localparam int PROD_W       = 2 * COORD_BITS;
    localparam int TERM_W       = PROD_W + 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
    localparam int NUM_EDGES    = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Operands of one edge, ready for the multipliers.
    typedef struct packed {
        logic                      crosses;
        logic                      dy_pos;
        logic signed [DIFF_W-1:0]  lhs_a;
        logic signed [DIFF_W-1:0]  lhs_b;
        logic signed [DIFF_W-1:0]  rhs_a;
        logic signed [DIFF_W-1:0]  rhs_b;
        coord_t                    ar_bx;
        coord_t                    ar_ay;
        coord_t                    ar_ax;
        coord_t                    ar_by;
    } edge_ops_t;

    // Products of one edge.
    typedef struct packed {
        logic                      crosses;
        logic                      dy_pos;
        logic signed [CROSS_W-1:0] lhs;
        logic signed [CROSS_W-1:0] rhs;
        logic signed [PROD_W-1:0]  pa;
        logic signed [PROD_W-1:0]  pb;
    } edge_prod_t;

    // Per-vertex control carried down the pipeline.
    typedef struct packed {
        logic first;
        logic last;
        logic too_many;
    } vtx_ctrl_t;

    // Set up one edge a->b against point p; a disabled edge contributes nothing.
    function automatic edge_ops_t make_edge(input coord_t ax, input coord_t ay,
                                            input coord_t bx, input coord_t by,
                                            input coord_t px, input coord_t py,
                                            input logic en);
        edge_ops_t                ops;
        logic signed [DIFF_W-1:0] dy;
        ops = '0;
        dy  = DIFF_W'(by) - DIFF_W'(ay);
        if (en) begin
            ops.crosses = ((ay <= py) && (py < by)) || ((by <= py) && (py < ay));
            ops.dy_pos  = ~dy[DIFF_W-1];
            ops.lhs_a   = DIFF_W'(px) - DIFF_W'(ax);
            ops.lhs_b   = dy;
            ops.rhs_a   = DIFF_W'(bx) - DIFF_W'(ax);
            ops.rhs_b   = DIFF_W'(py) - DIFF_W'(ay);
            ops.ar_bx   = bx;
            ops.ar_ay   = ay;
            ops.ar_ax   = ax;
            ops.ar_by   = by;
        end
        return ops;
    endfunction

endpackage

// ===== sv/pip_front.sv =====
// Input stage: polygon state, vertex count and registered edge operands.
module pip_front import pip_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  coord_t    s_vertex_x,
    input  coord_t    s_vertex_y,
    input  coord_t    s_query_x,
    input  coord_t    s_query_y,
    input  logic      s_last_vertex,
    input  logic      s1_take,
    output logic      s1_valid,
    output vtx_ctrl_t s1_ctrl,
    output edge_ops_t s1_ops [NUM_EDGES]
);

    logic             valid_reg;
    vtx_ctrl_t        ctrl_reg;
    edge_ops_t        ops_reg [NUM_EDGES];
    logic [CNT_W-1:0] count_reg, count_next;
    coord_t           first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    coord_t           point_x_reg, point_y_reg;
    logic             s_fire, is_first;
    coord_t           px, py, fx, fy;
    edge_ops_t        ops_next [NUM_EDGES];

    assign s_ready  = ~valid_reg | s1_take;
    assign s_fire   = s_valid & s_ready;
    assign is_first = (count_reg == '0);

    always_comb begin
        px = is_first ? s_query_x  : point_x_reg;
        py = is_first ? s_query_y  : point_y_reg;
        fx = is_first ? s_vertex_x : first_x_reg;
        fy = is_first ? s_vertex_y : first_y_reg;
        ops_next[0] = make_edge(prev_x_reg, prev_y_reg, s_vertex_x, s_vertex_y,
                                px, py, ~is_first);
        ops_next[1] = make_edge(s_vertex_x, s_vertex_y, fx, fy, px, py, s_last_vertex);
        if (s_last_vertex) begin
            count_next = '0;
        end else if (count_reg <= CNT_W'(MAX_VERTICES)) begin
            count_next = count_reg + CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= s_fire | (valid_reg & ~s1_take);
            if (s_fire) begin
                count_reg <= count_next;
            end
        end
        if (s_fire) begin
            prev_x_reg <= s_vertex_x;
            prev_y_reg <= s_vertex_y;
            if (is_first) begin
                first_x_reg <= s_vertex_x;
                first_y_reg <= s_vertex_y;
                point_x_reg <= s_query_x;
                point_y_reg <= s_query_y;
            end
            ctrl_reg.first    <= is_first;
            ctrl_reg.last     <= s_last_vertex;
            ctrl_reg.too_many <= (count_reg >= CNT_W'(MAX_VERTICES));
            ops_reg           <= ops_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_ctrl  = ctrl_reg;
    assign s1_ops   = ops_reg;

endmodule

// ===== sv/pip_mult.sv =====
// Multiply stage: crossing and shoelace products for both edges of a vertex.
module pip_mult import pip_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s1_valid,
    input  vtx_ctrl_t  s1_ctrl,
    input  edge_ops_t  s1_ops [NUM_EDGES],
    output logic       s1_take,
    input  logic       s2_take,
    output logic       s2_valid,
    output vtx_ctrl_t  s2_ctrl,
    output edge_prod_t s2_prod [NUM_EDGES]
);

    logic       valid_reg;
    vtx_ctrl_t  ctrl_reg;
    edge_prod_t prod_reg [NUM_EDGES];
    logic       load;

    assign s1_take = ~valid_reg | s2_take;
    assign load    = s1_valid & s1_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= load | (valid_reg & ~s2_take);
        end
        if (load) begin
            ctrl_reg <= s1_ctrl;
            for (int e = 0; e < NUM_EDGES; e++) begin
                prod_reg[e].crosses <= s1_ops[e].crosses;
                prod_reg[e].dy_pos  <= s1_ops[e].dy_pos;
                prod_reg[e].lhs     <= s1_ops[e].lhs_a * s1_ops[e].lhs_b;
                prod_reg[e].rhs     <= s1_ops[e].rhs_a * s1_ops[e].rhs_b;
                prod_reg[e].pa      <= s1_ops[e].ar_bx * s1_ops[e].ar_ay;
                prod_reg[e].pb      <= s1_ops[e].ar_ax * s1_ops[e].ar_by;
            end
        end
    end

    assign s2_valid = valid_reg;
    assign s2_ctrl  = ctrl_reg;
    assign s2_prod  = prod_reg;

endmodule

// ===== sv/pip_accum.sv =====
// Accumulate stage: crossing parity, doubled area and the result register.
module pip_accum import pip_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s2_valid,
    input  vtx_ctrl_t                   s2_ctrl,
    input  edge_prod_t                  s2_prod [NUM_EDGES],
    output logic                        s2_take,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_inside_res,
    output logic                        m_is_hole,
    output logic signed [AREA_BITS-1:0] m_area_doubled,
    output logic                        m_too_many
);

    logic                        parity_reg, parity_next;
    logic signed [AREA_BITS-1:0] area_reg, area_next;
    logic                        m_valid_reg;
    logic                        inside_reg, hole_reg, too_many_reg;
    logic signed [AREA_BITS-1:0] area_out_reg;
    logic                        fire;
    logic signed [TERM_W-1:0]    term [NUM_EDGES];
    logic [NUM_EDGES-1:0]        hit;

    // Hold a vertex that closes a polygon while the previous result still waits.
    assign s2_take = ~s2_ctrl.last | ~m_valid_reg | m_ready;
    assign fire    = s2_valid & s2_take;

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            hit[e]  = s2_prod[e].crosses & (s2_prod[e].dy_pos ?
                      (s2_prod[e].lhs <= s2_prod[e].rhs) :
                      (s2_prod[e].lhs >= s2_prod[e].rhs));
            term[e] = TERM_W'(s2_prod[e].pa) - TERM_W'(s2_prod[e].pb);
        end
        parity_next = (s2_ctrl.first ? 1'b0 : parity_reg) ^ (^hit);
        area_next   = (s2_ctrl.first ? '0 : area_reg)
                    + AREA_BITS'(term[0]) + AREA_BITS'(term[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (fire & s2_ctrl.last) | (m_valid_reg & ~m_ready);
        end
        if (fire) begin
            parity_reg <= parity_next;
            area_reg   <= area_next;
            if (s2_ctrl.last) begin
                hole_reg     <= area_next[AREA_BITS-1];
                inside_reg   <= parity_next ^ area_next[AREA_BITS-1];
                area_out_reg <= area_next;
                too_many_reg <= s2_ctrl.too_many;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_inside_res   = inside_reg;
    assign m_is_hole      = hole_reg;
    assign m_area_doubled = area_out_reg;
    assign m_too_many     = too_many_reg;

endmodule

// ===== sv/point_in_oriented_polygon_top.sv =====
// Top level of the streaming point-in-oriented-polygon tester.
//
// Feed one polygon vertex per transaction on the s_ channel, with the query
// point on the first vertex and s_last_vertex high on the final one. The block
// accepts one vertex every clock cycle and returns one result transaction per
// polygon on the m_ channel; m_valid is registered as the accumulator takes the
// last vertex. Each vertex runs through three registered stages:
// edge setup and crossing compares, a bank of eight parallel signed multipliers
// (crossing and shoelace products of the current and the closing edge), and
// the parity and doubled-area accumulator with the result register. The only
// stall is a closing vertex that reaches the accumulator while the previous
// result still waits on m_ready; it holds there, and the stages behind it hold,
// until that result is taken. The result is the
// crossing parity, inverted for holes (negative doubled area), the doubled
// area wrapped to 43 bits, and a flag for polygons of more than 1024 vertices.
// There is no clearing pass after reset; the block is ready at once.
module point_in_oriented_polygon_top import pip_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_vertex_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_y,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    input  logic                         s_last_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_inside_res,
    output logic                         m_is_hole,
    output logic signed [AREA_BITS-1:0]  m_area_doubled,
    output logic                         m_too_many
);

    // Stage handshakes: each stage advances when its successor can take it.
    logic       s1_valid, s1_take;
    vtx_ctrl_t  s1_ctrl;
    edge_ops_t  s1_ops [NUM_EDGES];
    logic       s2_valid, s2_take;
    vtx_ctrl_t  s2_ctrl;
    edge_prod_t s2_prod [NUM_EDGES];

    // Edge setup: track first, previous and query point, count vertices.
    pip_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_query_x     (s_query_x),
        .s_query_y     (s_query_y),
        .s_last_vertex (s_last_vertex),
        .s1_take       (s1_take),
        .s1_valid      (s1_valid),
        .s1_ctrl       (s1_ctrl),
        .s1_ops        (s1_ops)
    );

    // Products for the edge into this vertex and, on the last one, the closing edge.
    pip_mult u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid),
        .s1_ctrl  (s1_ctrl),
        .s1_ops   (s1_ops),
        .s1_take  (s1_take),
        .s2_take  (s2_take),
        .s2_valid (s2_valid),
        .s2_ctrl  (s2_ctrl),
        .s2_prod  (s2_prod)
    );

    // Fold crossings into parity, terms into the area; emit on the last vertex.
    pip_accum u_accum (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s2_valid       (s2_valid),
        .s2_ctrl        (s2_ctrl),
        .s2_prod        (s2_prod),
        .s2_take        (s2_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res),
        .m_is_hole      (m_is_hole),
        .m_area_doubled (m_area_doubled),
        .m_too_many     (m_too_many)
    );

endmodule

// ===== dv/pip_verdict_checker.sv =====
// Watches both channels of the polygon tester, predicts each verdict and compares it.
`timescale 1ns / 1ps

module pip_verdict_checker import pip_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  coord_t                      s_vertex_x,
    input  coord_t                      s_vertex_y,
    input  coord_t                      s_query_x,
    input  coord_t                      s_query_y,
    input  logic                        s_last_vertex,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_inside_res,
    input  logic                        m_is_hole,
    input  logic signed [AREA_BITS-1:0] m_area_doubled,
    input  logic                        m_too_many,
    output int                          mismatches,
    output int                          verdicts_pending
);

    typedef struct packed {
        logic                        in_region;
        logic                        hole;
        logic signed [AREA_BITS-1:0] area;
        logic                        too_many;
    } verdict_t;

    verdict_t verdicts_due[$];

    coord_t                ring_x0, ring_y0, last_x, last_y, probe_x, probe_y;
    logic                  crossings_odd;
    logic [AREA_BITS-1:0]  area_acc;
    int unsigned           vtx_seen;

    initial begin
        mismatches       = 0;
        verdicts_pending = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void clear_ring();
        ring_x0       = '0;
        ring_y0       = '0;
        last_x        = '0;
        last_y        = '0;
        probe_x       = '0;
        probe_y       = '0;
        crossings_odd = 1'b0;
        area_acc      = '0;
        vtx_seen      = 0;
    endfunction

    // Half-open crossing test on y with exact cross-multiplied x test, plus shoelace term.
    function automatic void walk_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint px, py, dy, lhs, rhs;
        logic   hit;
        px = probe_x;
        py = probe_y;
        if ((ay <= py && py < by) || (by <= py && py < ay)) begin
            dy  = by - ay;
            lhs = (px - ax) * dy;
            rhs = (bx - ax) * (py - ay);
            hit = (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
            if (hit)
                crossings_odd = ~crossings_odd;
        end
        area_acc = area_acc + AREA_BITS'(bx * ay - ax * by);
    endfunction

    function automatic void absorb_vertex(input coord_t vx, input coord_t vy,
                                          input coord_t qx, input coord_t qy,
                                          input logic last,
                                          output bit emit, output verdict_t v);
        logic hole;
        emit = 1'b0;
        v    = '0;
        if (vtx_seen == 0) begin
            probe_x       = qx;
            probe_y       = qy;
            ring_x0       = vx;
            ring_y0       = vy;
            crossings_odd = 1'b0;
            area_acc      = '0;
        end else begin
            walk_edge(last_x, last_y, vx, vy);
        end
        if (vtx_seen <= MAX_VERTICES)
            vtx_seen++;
        last_x = vx;
        last_y = vy;
        if (last) begin
            walk_edge(vx, vy, ring_x0, ring_y0);
            hole        = area_acc[AREA_BITS-1];
            v.in_region = crossings_odd ^ hole;
            v.hole      = hole;
            v.area      = area_acc;
            v.too_many  = (vtx_seen > MAX_VERTICES);
            emit        = 1'b1;
            clear_ring();
        end
    endfunction

    always @(posedge aclk) begin
        verdict_t fresh, want;
        bit       emit;
        if (!aresetn) begin
            clear_ring();
            verdicts_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                absorb_vertex(s_vertex_x, s_vertex_y, s_query_x, s_query_y, s_last_vertex,
                              emit, fresh);
                if (emit)
                    verdicts_due.push_back(fresh);
            end
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result transaction with no polygon pending");
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_inside_res !== want.in_region)
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  m_inside_res, want.in_region));
                    if (m_is_hole !== want.hole)
                        report_mismatch($sformatf("is_hole got %b want %b",
                                                  m_is_hole, want.hole));
                    if (m_area_doubled !== want.area)
                        report_mismatch($sformatf("area_doubled got %0d want %0d",
                                                  m_area_doubled, want.area));
                    if (m_too_many !== want.too_many)
                        report_mismatch($sformatf("too_many got %b want %b",
                                                  m_too_many, want.too_many));
                end
            end
        end
        verdicts_pending = verdicts_due.size();
    end

endmodule

// ===== dv/tb.sv =====
// Stimulus, handshake pacing and final verdict for the polygon tester.
`timescale 1ns / 1ps

module tb;
    import pip_pkg::*;

    // Spread of generated vertices around the query point.
    typedef enum logic [1:0] {
        SPREAD_WIDE,
        SPREAD_NEAR,
        SPREAD_GRID
    } spread_t;

    localparam coord_t C_HI        = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_LO        = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam longint C_HI_VAL    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint C_LO_VAL    = -(longint'(1) <<< (COORD_BITS - 1));
    localparam int     RANDOM_ITEMS = 1900;
    localparam int     WRAP_RING    = 2100;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     TAIL_CYCLES  = 10;

    logic   aclk          = 1'b0;
    logic   aresetn       = 1'b0;
    logic   s_valid       = 1'b0;
    logic   s_ready;
    coord_t s_vertex_x    = '0;
    coord_t s_vertex_y    = '0;
    coord_t s_query_x     = '0;
    coord_t s_query_y     = '0;
    logic   s_last_vertex = 1'b0;
    logic   m_valid;
    logic   m_ready       = 1'b0;
    logic   m_inside_res;
    logic   m_is_hole;
    logic   signed [AREA_BITS-1:0] m_area_doubled;
    logic   m_too_many;

    int     mismatches;
    int     verdicts_pending;
    int     items_sent  = 0;
    int     quiet_cycles = 0;
    bit     calm        = 1'b0;   // high: neither side idles

    // 2 ns clock, high phase then low phase.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    point_in_oriented_polygon_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_query_x     (s_query_x),
        .s_query_y     (s_query_y),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_is_hole     (m_is_hole),
        .m_area_doubled(m_area_doubled),
        .m_too_many    (m_too_many)
    );

    pip_verdict_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_vertex_x      (s_vertex_x),
        .s_vertex_y      (s_vertex_y),
        .s_query_x       (s_query_x),
        .s_query_y       (s_query_y),
        .s_last_vertex   (s_last_vertex),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res),
        .m_is_hole       (m_is_hole),
        .m_area_doubled  (m_area_doubled),
        .m_too_many      (m_too_many),
        .mismatches      (mismatches),
        .verdicts_pending(verdicts_pending)
    );

    // Stall the result channel at random, about 19 percent of the time, never during the calm stretch.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 19);
    end

    // Abort when no transaction moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one vertex; idle first at random, then hold valid and payload until accepted.
    task automatic send_vertex(input coord_t vx, input coord_t vy,
                               input coord_t qx, input coord_t qy, input logic last);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_vertex_x    <= vx;
        s_vertex_y    <= vy;
        s_query_x     <= qx;
        s_query_y     <= qy;
        s_last_vertex <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and hold off until every pending verdict has been returned.
    task automatic wait_verdicts_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge aclk);
    endtask

    // Pick a coordinate: anywhere, near the query point, or on a tight grid around it
    // so that vertices often share the query's y and hit the half-open boundary.
    function automatic coord_t pick_coord(input coord_t center, input spread_t spread);
        longint v;
        int     off;
        if (spread == SPREAD_WIDE)
            return coord_t'($urandom);
        if (spread == SPREAD_NEAR)
            off = int'($urandom_range(400)) - 200;
        else
            off = int'($urandom_range(8)) - 4;
        v = longint'(center) + off;
        if (v > C_HI_VAL)
            v = C_HI_VAL;
        else if (v < C_LO_VAL)
            v = C_LO_VAL;
        return coord_t'(v);
    endfunction

    // Send one polygon of n vertices; query fields on later vertices carry junk.
    task automatic send_ring(input int n, input spread_t spread);
        coord_t qx, qy;
        int     i;
        qx = coord_t'($urandom);
        qy = coord_t'($urandom);
        for (i = 0; i < n; i++) begin
            if (i == 0)
                send_vertex(pick_coord(qx, spread), pick_coord(qy, spread), qx, qy, n == 1);
            else
                send_vertex(pick_coord(qx, spread), pick_coord(qy, spread),
                            coord_t'($urandom), coord_t'($urandom), i == n - 1);
        end
    endtask

    initial begin
        int      base;
        int      n;
        int      pick;
        int      i;
        bit      squeezed;
        spread_t spread;

        squeezed = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single-vertex polygons at the coordinate extremes: degenerate edge only.
        send_vertex(C_HI, C_LO, C_LO, C_HI, 1'b1);
        send_vertex(C_LO, C_HI, C_HI, C_LO, 1'b1);

        // Two vertices spanning the whole range, query on the segment.
        send_vertex(C_LO, C_LO, 16'sd0, 16'sd0, 1'b0);
        send_vertex(C_HI, C_HI, C_HI, C_LO, 1'b1);

        // Triangle with a horizontal edge, both orientations (filled and hole).
        send_vertex(16'sd0,   16'sd0,   16'sd10, 16'sd10, 1'b0);
        send_vertex(16'sd0,   16'sd100, C_LO,    C_HI,    1'b0);
        send_vertex(16'sd100, 16'sd0,   C_HI,    C_LO,    1'b1);
        send_vertex(16'sd0,   16'sd0,   16'sd10, 16'sd10, 1'b0);
        send_vertex(16'sd100, 16'sd0,   16'sd5,  16'sd5,  1'b0);
        send_vertex(16'sd0,   16'sd100, -16'sd5, -16'sd5, 1'b1);

        // Full-range square: query at the center, then on a corner.
        send_vertex(C_LO, C_LO, 16'sd0, 16'sd0, 1'b0);
        send_vertex(C_LO, C_HI, C_HI, C_HI, 1'b0);
        send_vertex(C_HI, C_HI, C_LO, C_LO, 1'b0);
        send_vertex(C_HI, C_LO, C_HI, C_LO, 1'b1);
        send_vertex(C_LO, C_LO, C_LO, C_LO, 1'b0);
        send_vertex(C_LO, C_HI, 16'sd0, 16'sd0, 1'b0);
        send_vertex(C_HI, C_HI, 16'sd0, 16'sd0, 1'b0);
        send_vertex(C_HI, C_LO, 16'sd0, 16'sd0, 1'b1);

        // Diamond whose side vertices sit exactly on the query's y.
        send_vertex(-16'sd5, 16'sd0,  16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd0,  16'sd5,  16'sd1, 16'sd1, 1'b0);
        send_vertex(16'sd5,  16'sd0,  16'sd2, 16'sd2, 1'b0);
        send_vertex(16'sd0,  -16'sd5, 16'sd3, 16'sd3, 1'b1);

        // Pause the sender until the directed verdicts are all back.
        wait_verdicts_drained();

        // Vertex count right at the limit, then one past it.
        send_ring(MAX_VERTICES, SPREAD_NEAR);
        send_ring(MAX_VERTICES + 1, SPREAD_GRID);

        // Walk the full-range square again and again: the area sum wraps past the
        // sign bit, so the hole flag flips, and the count saturates.
        for (i = 0; i < WRAP_RING; i++) begin
            send_vertex(((i % 4) < 2) ? C_LO : C_HI,
                        ((i % 4) == 0 || (i % 4) == 3) ? C_LO : C_HI,
                        coord_t'($urandom), coord_t'($urandom), i == WRAP_RING - 1);
        end

        // Random polygons: mostly short rings, a few single and two-vertex ones, some long.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            calm = (items_sent - base >= 700) && (items_sent - base < 1000);
            if (!squeezed && items_sent - base >= 1200) begin
                squeezed = 1'b1;
                wait_verdicts_drained();
            end
            pick = $urandom_range(99);
            if (pick < 5)
                n = 1;
            else if (pick < 10)
                n = 2;
            else if (pick < 90)
                n = $urandom_range(10, 3);
            else
                n = $urandom_range(40, 11);
            pick = $urandom_range(99);
            spread = (pick < 30) ? SPREAD_WIDE : (pick < 65) ? SPREAD_NEAR : SPREAD_GRID;
            send_ring(n, spread);
        end
        calm = 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        wait_verdicts_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
